### rtl/dap_pkg.sv
package dap_pkg;

    localparam int DELAY_DEPTH_DEF  = 65536;
    localparam int SAMPLE_WIDTH_DEF = 24;

    localparam int COEF_WIDTH  = 16;
    localparam int COEF_FRAC   = 15;
    localparam int DELAY_WIDTH = 16;

    // Control from the sequencer to the delay line
    typedef struct packed {
        logic start;   // request accepted: latch read address
        logic write;   // store the feedback word and advance the pointer
    } line_ctl_t;

endpackage

### rtl/dap_in_if.sv
interface dap_in_if #(
    parameter int SAMPLE_WIDTH = dap_pkg::SAMPLE_WIDTH_DEF
);
    logic                                 valid;
    logic                                 ready;
    logic signed [SAMPLE_WIDTH-1:0]       sample_in;
    logic signed [dap_pkg::COEF_WIDTH-1:0] coefficient;
    logic [dap_pkg::DELAY_WIDTH-1:0]      delay_samples;

    modport source (
        output valid,
        output sample_in,
        output coefficient,
        output delay_samples,
        input  ready
    );

    modport sink (
        input  valid,
        input  sample_in,
        input  coefficient,
        input  delay_samples,
        output ready
    );
endinterface

### rtl/dap_out_if.sv
interface dap_out_if #(
    parameter int SAMPLE_WIDTH = dap_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;

    modport source (
        output valid,
        output sample_out,
        input  ready
    );

    modport sink (
        input  valid,
        input  sample_out,
        output ready
    );
endinterface

### rtl/delayed_allpass_filter.sv
// Schroeder allpass on a delay line, one audio channel.
// Input channel (in_chan): sample_in, coefficient a (Q1.15) and delay_samples,
// one request per sample. Output channel (out_chan): sample_out, one result
// per request, in order.
// Per request: y = sat(round(x*a) + line[wp - delay]), then
// line[wp] = sat(x - round(y*a)) and wp advances with wrap.
// The result enters the output register at write-back, after the read, sum
// and multiply steps. The block takes no new request before the previous one
// reaches write-back: the next request is taken in the cycle that writes back
// the previous one. The four steps are the read of the single-port-read delay
// memory, the first sum, the second multiply and the write-back.
// Delay values of 0 act as 1, values above DELAY_DEPTH-1 act as DELAY_DEPTH-1.
// Reset empties the line at once: entries not yet written since reset read
// as zero, tracked by the write pointer and a wrap flag.
// A stalled receiver holds the result in the output register; the block
// still takes the next request and waits at write-back until the output
// register frees up.
module delayed_allpass_filter #(
    parameter int DELAY_DEPTH  = dap_pkg::DELAY_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = dap_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    dap_in_if.sink    in_chan,
    dap_out_if.source out_chan
);
    localparam int SW = SAMPLE_WIDTH;
    localparam int CW = dap_pkg::COEF_WIDTH;
    localparam int PW = SW + CW;
    localparam int FR = dap_pkg::COEF_FRAC;
    localparam logic signed [PW-1:0] HALF = PW'(1) <<< (FR - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SUM,
        S_MUL,
        S_WRITE
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic signed [SW-1:0] out_data_reg;

    logic signed [SW-1:0] x_reg;
    logic signed [CW-1:0] a_reg;
    logic signed [PW-1:0] p1_reg;
    logic signed [SW-1:0] y_reg;
    logic signed [PW-1:0] p2_reg;

    logic finish;
    logic accept;
    dap_pkg::line_ctl_t line_ctl;
    logic signed [SW-1:0] line_rd;
    logic signed [SW-1:0] y_next;
    logic signed [SW-1:0] w_next;
    logic signed [PW-1:0] p1_rnd;
    logic signed [PW-1:0] p2_rnd;
    logic signed [SW+1:0] y_sum;
    logic signed [SW+1:0] w_sum;

    function automatic logic signed [SW-1:0] sat(input logic signed [SW+1:0] v);
        logic signed [SW-1:0] r;
        if ((v[SW+1:SW-1] == 3'b000) || (v[SW+1:SW-1] == 3'b111))
            r = v[SW-1:0];
        else if (v[SW+1])
            r = {1'b1, {(SW - 1){1'b0}}};
        else
            r = {1'b0, {(SW - 1){1'b1}}};
        return r;
    endfunction

    assign finish = (state_reg == S_WRITE) && (!out_valid_reg || out_chan.ready);
    assign in_chan.ready = (state_reg == S_IDLE) || finish;
    assign accept = in_chan.valid && in_chan.ready;

    assign line_ctl.start = accept;
    assign line_ctl.write = finish;

    // Round to nearest, ties up: add half an LSB, then drop the fraction
    always_comb
    begin
        p1_rnd = p1_reg + HALF;
        p2_rnd = p2_reg + HALF;
        y_sum  = {p1_rnd[PW-1], p1_rnd[PW-1:FR]} + {{2{line_rd[SW-1]}}, line_rd};
        w_sum  = {{2{x_reg[SW-1]}}, x_reg} - {p2_rnd[PW-1], p2_rnd[PW-1:FR]};
        y_next = sat(y_sum);
        w_next = sat(w_sum);
    end

    dap_line #(
        .DELAY_DEPTH  (DELAY_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_line (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (line_ctl),
        .delay_samples (in_chan.delay_samples),
        .wr_data       (w_next),
        .rd_data       (line_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (finish)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= y_reg;
            end
            else if (out_chan.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (accept)
            begin
                state_reg <= S_READ;
            end
            else
            begin
                case (state_reg)
                    S_IDLE:  state_reg <= S_IDLE;
                    S_READ:  state_reg <= S_SUM;
                    S_SUM:   state_reg <= S_MUL;
                    S_MUL:   state_reg <= S_WRITE;
                    S_WRITE:
                    begin
                        if (finish)
                            state_reg <= S_IDLE;
                    end
                    default: state_reg <= S_IDLE;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg  <= in_chan.sample_in;
            a_reg  <= in_chan.coefficient;
            p1_reg <= in_chan.sample_in * in_chan.coefficient;
        end
        if (state_reg == S_SUM)
            y_reg <= y_next;
        if (state_reg == S_MUL)
            p2_reg <= y_reg * a_reg;
    end

    assign out_chan.valid      = out_valid_reg;
    assign out_chan.sample_out = out_data_reg;

endmodule

### rtl/dap_line.sv
module dap_line #(
    parameter int DELAY_DEPTH  = dap_pkg::DELAY_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = dap_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  dap_pkg::line_ctl_t               ctl,
    input  logic [dap_pkg::DELAY_WIDTH-1:0]  delay_samples,
    input  logic signed [SAMPLE_WIDTH-1:0]   wr_data,
    output logic signed [SAMPLE_WIDTH-1:0]   rd_data
);
    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int DW = (AW > dap_pkg::DELAY_WIDTH) ? AW : dap_pkg::DELAY_WIDTH;
    localparam logic [DW-1:0] MAX_DELAY = DW'(DELAY_DEPTH - 1);
    localparam logic [DW:0]   DEPTH_W   = (DW + 1)'(DELAY_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);

    logic signed [SAMPLE_WIDTH-1:0] mem [DELAY_DEPTH];

    logic [AW-1:0] wp_reg;
    logic [AW-1:0] wp_next;
    logic          wrapped_reg;
    logic          wrapped_next;
    logic [AW-1:0] rd_addr_reg;
    logic [AW-1:0] rd_addr_next;
    logic          rd_ok_reg;
    logic          rd_ok_next;
    logic          rd_word_ok_reg;
    logic signed [SAMPLE_WIDTH-1:0] rd_word_reg;

    logic [DW-1:0] del_raw;
    logic [DW-1:0] del_c;
    logic [DW:0]   wp_ext;
    logic [DW:0]   diff;

    // Pointer as it stands after a write in this same cycle
    always_comb
    begin
        wp_next      = wp_reg;
        wrapped_next = wrapped_reg;
        if (ctl.write)
        begin
            if (wp_reg == LAST_ADDR)
            begin
                wp_next      = '0;
                wrapped_next = 1'b1;
            end
            else
            begin
                wp_next = wp_reg + AW'(1);
            end
        end
    end

    always_comb
    begin
        del_raw = DW'(delay_samples);
        if (del_raw == '0)
            del_c = DW'(1);
        else if (del_raw > MAX_DELAY)
            del_c = MAX_DELAY;
        else
            del_c = del_raw;

        wp_ext = (DW + 1)'(wp_next);
        diff   = wp_ext - {1'b0, del_c};
        // Borrow means the tap lies behind address zero: wrap around
        if (diff[DW])
            diff = diff + DEPTH_W;
        rd_addr_next = diff[AW-1:0];
        // Before the first wrap only addresses below the pointer hold data
        rd_ok_next   = wrapped_next || (wp_ext >= {1'b0, del_c});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg         <= '0;
            wrapped_reg    <= 1'b0;
            rd_addr_reg    <= '0;
            rd_ok_reg      <= 1'b0;
            rd_word_ok_reg <= 1'b0;
        end
        else
        begin
            wp_reg      <= wp_next;
            wrapped_reg <= wrapped_next;
            if (ctl.start)
            begin
                rd_addr_reg <= rd_addr_next;
                rd_ok_reg   <= rd_ok_next;
            end
            rd_word_ok_reg <= rd_ok_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.write)
            mem[wp_reg] <= wr_data;
        rd_word_reg <= mem[rd_addr_reg];
    end

    assign rd_data = rd_word_ok_reg ? rd_word_reg : '0;

endmodule
